// ===== hw/rtl/crc8df_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8df_pkg
// Shared constants and the byte-wide CRC-8 update for the frame deframer.
// ----------------------------------------------------------------------------
package crc8df_pkg;

    localparam logic [7:0] HDR_FIRST   = 8'h55;
    localparam logic [7:0] HDR_SECOND  = 8'hAA;
    localparam logic [7:0] CRC_POLY    = 8'h8C;
    localparam logic [7:0] MIN_PAYLOAD = 8'd5;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_HDR_ERR = 2'd1;
    localparam t_status ST_CRC_ERR = 2'd2;
    localparam t_status ST_BAD_LEN = 2'd3;

    // Reflected CRC-8, one whole byte per call (eight shift steps).
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/crc8_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_frame_deframer
// Parses length-prefixed serial frames with a reflected CRC-8 check.
// ----------------------------------------------------------------------------
// How to use this block:
// Received bytes arrive as items on the input channel (i_in_valid, i_rx_byte,
// o_in_stall). Frames look like 0x55 0xAA, length L, L payload bytes, a CRC
// byte and two trailer bytes. A reflected CRC-8 (polynomial 0x8C, start 0)
// covers the header, the length and the payload.
// The output channel (o_out_valid, o_status, o_speed_one, o_speed_two,
// o_control_flags, i_out_stall) carries at most one item per input byte: the
// frame result on the CRC byte, a bad-length report on the length byte, or a
// header error, which is reported once until a full header is seen again.
// Error results carry zero in the speed and flag fields.
// Timing: an accepted byte is held in an input register and is parsed from
// there while the result register is free; its result goes into the result
// register. The parser takes one byte per cycle unless a blocked result stalls
// it, limited by the byte-wide CRC update and the phase step between the
// input and result registers. When the receiver stalls with a result waiting,
// the byte in the input register is held and o_in_stall is high until the
// result is taken. Synchronous reset empties both registers and returns the
// parser to hunting for the first header byte.
// ----------------------------------------------------------------------------
module crc8_frame_deframer #(
    parameter int MAX_PAYLOAD = 128
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [7:0]               i_rx_byte,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output crc8df_pkg::t_status      o_status,
    output logic signed [15:0]       o_speed_one,
    output logic signed [15:0]       o_speed_two,
    output logic [7:0]               o_control_flags
);
    import crc8df_pkg::*;

    // Parser phase codes; the unused code behaves as hunting.
    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_HDR2  = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_CRC   = 3'd4;
    localparam logic [2:0] PH_TAIL0 = 3'd5;
    localparam logic [2:0] PH_TAIL1 = 3'd6;

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Parser state.
    logic [2:0]  r_phase,   n_phase;
    logic [7:0]  r_idx,     n_idx;
    logic [7:0]  r_len,     n_len;
    logic [7:0]  r_crc,     n_crc;
    logic [15:0] r_spd1,    n_spd1;
    logic [15:0] r_spd2,    n_spd2;
    logic [7:0]  r_flags,   n_flags;
    logic        r_hdr_err_sent, n_hdr_err_sent;

    // Result register.
    logic        r_out_valid;
    t_status     r_status;
    logic [15:0] r_out_spd1;
    logic [15:0] r_out_spd2;
    logic [7:0]  r_out_flags;

    // Result of parsing the held byte.
    logic        n_res_valid;
    t_status     n_res_status;
    logic [15:0] n_res_spd1;
    logic [15:0] n_res_spd2;
    logic [7:0]  n_res_flags;

    logic       out_free;
    logic       advance;
    logic       in_accept;
    logic [7:0] idx_inc;
    logic [7:0] b;

    // The held byte is parsed when the result register can take whatever it yields.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign b       = r_in_byte;
    assign idx_inc = r_idx + 8'd1;

    always_comb begin
        n_phase        = r_phase;
        n_idx          = r_idx;
        n_len          = r_len;
        n_crc          = r_crc;
        n_spd1         = r_spd1;
        n_spd2         = r_spd2;
        n_flags        = r_flags;
        n_hdr_err_sent = r_hdr_err_sent;
        n_res_valid    = 1'b0;
        n_res_status   = ST_OK;
        n_res_spd1     = '0;
        n_res_spd2     = '0;
        n_res_flags    = '0;

        unique case (r_phase)
            PH_HDR2: begin
                if (b == HDR_SECOND) begin
                    n_crc          = crc8_update(r_crc, b);
                    n_hdr_err_sent = 1'b0;
                    n_phase        = PH_LEN;
                end else begin
                    if (!r_hdr_err_sent) begin
                        n_res_valid    = 1'b1;
                        n_res_status   = ST_HDR_ERR;
                        n_hdr_err_sent = 1'b1;
                    end
                    // A repeated first header byte restarts the header.
                    if (b == HDR_FIRST) begin
                        n_crc   = crc8_update(8'd0, b);
                        n_phase = PH_HDR2;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
            end
            PH_LEN: begin
                if (b < MIN_PAYLOAD || b > MAX_LEN) begin
                    n_res_valid  = 1'b1;
                    n_res_status = ST_BAD_LEN;
                    n_phase      = PH_HUNT;
                end else begin
                    n_crc   = crc8_update(r_crc, b);
                    n_len   = b;
                    n_idx   = 8'd0;
                    n_spd1  = '0;
                    n_spd2  = '0;
                    n_flags = '0;
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                n_crc = crc8_update(r_crc, b);
                unique case (r_idx)
                    8'd0:    n_spd1[7:0]  = b;
                    8'd1:    n_spd1[15:8] = b;
                    8'd2:    n_spd2[7:0]  = b;
                    8'd3:    n_spd2[15:8] = b;
                    8'd4:    n_flags      = b;
                    default: ;
                endcase
                n_idx = idx_inc;
                if (idx_inc >= r_len) begin
                    n_phase = PH_CRC;
                end
            end
            PH_CRC: begin
                n_res_valid = 1'b1;
                if (b == r_crc) begin
                    n_res_status = ST_OK;
                    n_res_spd1   = r_spd1;
                    n_res_spd2   = r_spd2;
                    n_res_flags  = r_flags;
                end else begin
                    n_res_status = ST_CRC_ERR;
                end
                n_phase = PH_TAIL0;
            end
            PH_TAIL0: n_phase = PH_TAIL1;
            PH_TAIL1: n_phase = PH_HUNT;
            default: begin
                if (b == HDR_FIRST) begin
                    n_crc   = crc8_update(8'd0, b);
                    n_phase = PH_HDR2;
                end else begin
                    if (!r_hdr_err_sent) begin
                        n_res_valid    = 1'b1;
                        n_res_status   = ST_HDR_ERR;
                        n_hdr_err_sent = 1'b1;
                    end
                    n_phase = PH_HUNT;
                end
            end
        endcase
    end

    // Input register and parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_phase        <= PH_HUNT;
            r_idx          <= '0;
            r_len          <= '0;
            r_crc          <= '0;
            r_spd1         <= '0;
            r_spd2         <= '0;
            r_flags        <= '0;
            r_hdr_err_sent <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_phase        <= n_phase;
                r_idx          <= n_idx;
                r_len          <= n_len;
                r_crc          <= n_crc;
                r_spd1         <= n_spd1;
                r_spd2         <= n_spd2;
                r_flags        <= n_flags;
                r_hdr_err_sent <= n_hdr_err_sent;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_res_valid) begin
            r_status    <= n_res_status;
            r_out_spd1  <= n_res_spd1;
            r_out_spd2  <= n_res_spd2;
            r_out_flags <= n_res_flags;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_speed_one     = signed'(r_out_spd1);
    assign o_speed_two     = signed'(r_out_spd2);
    assign o_control_flags = r_out_flags;

    // Error results never carry frame data.
    a_err_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |->
            (o_speed_one == 16'sd0 && o_speed_two == 16'sd0 && o_control_flags == 8'd0))
        else $error("error result with nonzero payload fields");

    // Reporting a header error arms the suppression flag.
    a_hdr_err_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_res_valid && n_res_status == ST_HDR_ERR) |=> r_hdr_err_sent)
        else $error("header error reported without setting the flag");

    // The payload phase only runs with a legal length.
    a_len_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_len >= MIN_PAYLOAD && r_len <= MAX_LEN))
        else $error("payload phase with illegal length");

    // Back-pressure only while a byte is held and the result slot is blocked.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CRC-8 frame deframer. A queue of received
// bytes (directed frames, then random frames, noise and broken headers) is
// played into the block. A parser model run on every accepted byte predicts
// the frame results, and each result that leaves the block is checked field
// by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    import crc8df_pkg::*;

    localparam int MAX_LEN      = 128;   // payload limit given to the block
    localparam int RANDOM_BYTES = 1000;  // size of the random part, in items
    localparam int QUIET_LIMIT  = 2000;  // cycles without any handshake
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 8;     // settle time after the last result

    // Parser phases of the model, in the order a frame walks through them.
    typedef enum logic [2:0] {
        SEEK_SYNC0,
        SEEK_SYNC1,
        GET_LEN,
        GET_PAYLOAD,
        GET_CRC,
        SKIP_TAIL0,
        SKIP_TAIL1
    } t_parse_state;

    typedef struct {
        t_status            status;
        logic signed [15:0] speed_one;
        logic signed [15:0] speed_two;
        logic [7:0]         flags;
    } t_frame_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic [7:0]         i_rx_byte = 8'h00;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_status            o_status;
    logic signed [15:0] o_speed_one;
    logic signed [15:0] o_speed_two;
    logic [7:0]         o_control_flags;

    // Bytes still to be sent, and frame results predicted but not yet seen.
    logic [7:0]    rx_bytes[$];
    t_frame_result pending_results[$];

    int n_items     = 1;
    int n_accepted  = 0;
    int n_errors    = 0;
    int quiet_count = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    bit rx_taken    = 1'b0;

    // Model state of the frame parser.
    t_parse_state pstate = SEEK_SYNC0;
    logic [7:0]   pay_idx = 8'd0;
    logic [7:0]   pay_len = 8'd0;
    logic [7:0]   crc_acc = 8'd0;
    logic [15:0]  sp1_acc = 16'd0;
    logic [15:0]  sp2_acc = 16'd0;
    logic [7:0]   flags_acc = 8'd0;
    logic         hdr_err_reported = 1'b0;

    always #5 i_clk = ~i_clk;

    crc8_frame_deframer #(
        .MAX_PAYLOAD(MAX_LEN)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_rx_byte(i_rx_byte),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_status(o_status),
        .o_speed_one(o_speed_one),
        .o_speed_two(o_speed_two),
        .o_control_flags(o_control_flags)
    );

    // Reflected CRC-8, fed one bit at a time from the LSB of the byte.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] acc;
        logic       fb;
        acc = crc;
        for (int i = 0; i < 8; i++) begin
            fb  = acc[0] ^ b[i];
            acc = acc >> 1;
            if (fb) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    // The run goes through three idling regimes, one third of the items each.
    function automatic int idle_regime();
        return (n_accepted * 3) / n_items;
    endfunction

    function automatic void predict_result(input t_status st, input logic [15:0] s1,
                                           input logic [15:0] s2, input logic [7:0] fl);
        t_frame_result r;
        r.status    = st;
        r.speed_one = s1;
        r.speed_two = s2;
        r.flags     = fl;
        pending_results.push_back(r);
    endfunction

    // A header error is reported once; after that the parser hunts silently
    // until a complete 0x55 0xAA header has been seen.
    function automatic void header_mismatch();
        if (!hdr_err_reported) begin
            hdr_err_reported = 1'b1;
            predict_result(ST_HDR_ERR, 16'd0, 16'd0, 8'd0);
        end
    endfunction

    // Advance the parser model by one accepted byte.
    function automatic void deframe_byte(input logic [7:0] b);
        case (pstate)
            SEEK_SYNC1: begin
                if (b == HDR_SECOND) begin
                    crc_acc          = crc8_step(crc_acc, b);
                    hdr_err_reported = 1'b0;
                    pstate           = GET_LEN;
                end else begin
                    header_mismatch();
                    // A repeated 0x55 simply restarts the header.
                    if (b == HDR_FIRST) begin
                        crc_acc = crc8_step(8'd0, b);
                        pstate  = SEEK_SYNC1;
                    end else begin
                        pstate = SEEK_SYNC0;
                    end
                end
            end
            GET_LEN: begin
                if (b < MIN_PAYLOAD || b > MAX_LEN) begin
                    predict_result(ST_BAD_LEN, 16'd0, 16'd0, 8'd0);
                    pstate = SEEK_SYNC0;
                end else begin
                    crc_acc   = crc8_step(crc_acc, b);
                    pay_len   = b;
                    pay_idx   = 8'd0;
                    sp1_acc   = 16'd0;
                    sp2_acc   = 16'd0;
                    flags_acc = 8'd0;
                    pstate    = GET_PAYLOAD;
                end
            end
            GET_PAYLOAD: begin
                crc_acc = crc8_step(crc_acc, b);
                case (pay_idx)
                    8'd0: sp1_acc[7:0]  = b;
                    8'd1: sp1_acc[15:8] = b;
                    8'd2: sp2_acc[7:0]  = b;
                    8'd3: sp2_acc[15:8] = b;
                    8'd4: flags_acc     = b;
                    default: ;
                endcase
                pay_idx = pay_idx + 8'd1;
                if (pay_idx >= pay_len) begin
                    pstate = GET_CRC;
                end
            end
            GET_CRC: begin
                if (b == crc_acc) begin
                    predict_result(ST_OK, sp1_acc, sp2_acc, flags_acc);
                end else begin
                    predict_result(ST_CRC_ERR, 16'd0, 16'd0, 8'd0);
                end
                pstate = SKIP_TAIL0;
            end
            SKIP_TAIL0: pstate = SKIP_TAIL1;
            SKIP_TAIL1: pstate = SEEK_SYNC0;
            default: begin
                if (b == HDR_FIRST) begin
                    crc_acc = crc8_step(8'd0, b);
                    pstate  = SEEK_SYNC1;
                end else begin
                    header_mismatch();
                    pstate = SEEK_SYNC0;
                end
            end
        endcase
    endfunction

    // Queue one whole frame. The first five payload bytes come from head
    // (byte 0 in the low bits); any further payload bytes are random.
    function automatic void queue_frame(input logic [7:0] len, input logic [39:0] head,
                                        input bit bad_crc);
        logic [7:0] crc;
        logic [7:0] b;
        crc = 8'd0;
        rx_bytes.push_back(HDR_FIRST);
        crc = crc8_step(crc, HDR_FIRST);
        rx_bytes.push_back(HDR_SECOND);
        crc = crc8_step(crc, HDR_SECOND);
        rx_bytes.push_back(len);
        crc = crc8_step(crc, len);
        for (int i = 0; i < len; i++) begin
            b = (i < 5) ? head[8*i +: 8] : 8'($urandom());
            rx_bytes.push_back(b);
            crc = crc8_step(crc, b);
        end
        rx_bytes.push_back(bad_crc ? (crc ^ 8'($urandom_range(1, 255))) : crc);
        // The trailer is not checked by the block, so it is often garbage.
        if ($urandom_range(1)) begin
            rx_bytes.push_back(8'h0D);
            rx_bytes.push_back(8'h0A);
        end else begin
            rx_bytes.push_back(8'($urandom()));
            rx_bytes.push_back(8'($urandom()));
        end
    endfunction

    // Stimulus, reset and end of run.
    initial begin
        int         r;
        int         n_directed;
        logic [7:0] len;

        // Directed part. Stray bytes while hunting: only the first one is
        // reported as a header error.
        rx_bytes.push_back(8'h00);
        rx_bytes.push_back(8'hFF);
        // A doubled first header byte, then a minimum-length frame that
        // carries the most negative and most positive speeds.
        rx_bytes.push_back(HDR_FIRST);
        queue_frame(8'd5, {8'hFF, 8'h7F, 8'hFF, 8'h80, 8'h00}, 1'b0);
        // Lengths just outside the legal range on both sides.
        rx_bytes.push_back(HDR_FIRST);
        rx_bytes.push_back(HDR_SECOND);
        rx_bytes.push_back(MIN_PAYLOAD - 8'd1);
        rx_bytes.push_back(HDR_FIRST);
        rx_bytes.push_back(HDR_SECOND);
        rx_bytes.push_back(8'(MAX_LEN + 1));
        // A wrong second header byte after a good header had cleared the flag.
        rx_bytes.push_back(HDR_FIRST);
        rx_bytes.push_back(8'h13);
        // A frame whose CRC byte is wrong.
        queue_frame(8'd5, {$urandom(), 8'($urandom())}, 1'b1);
        n_directed = rx_bytes.size();

        // Random part: mostly well-formed frames, the rest noise and broken
        // header or length sequences.
        while (rx_bytes.size() < n_directed + RANDOM_BYTES) begin
            r = $urandom_range(99);
            if (r < 70) begin
                r = $urandom_range(99);
                if (r < 2) begin
                    len = 8'(MAX_LEN);
                end else if (r < 5) begin
                    len = 8'($urandom_range(5, MAX_LEN));
                end else begin
                    len = 8'($urandom_range(5, 16));
                end
                queue_frame(len, {$urandom(), 8'($urandom())}, $urandom_range(99) < 15);
            end else if (r < 80) begin
                repeat ($urandom_range(1, 4)) rx_bytes.push_back(8'($urandom()));
            end else if (r < 88) begin
                rx_bytes.push_back(HDR_FIRST);
                rx_bytes.push_back(HDR_SECOND);
                if ($urandom_range(1)) begin
                    rx_bytes.push_back(8'($urandom_range(0, MIN_PAYLOAD - 1)));
                end else begin
                    rx_bytes.push_back(8'($urandom_range(MAX_LEN + 1, 255)));
                end
            end else if (r < 94) begin
                rx_bytes.push_back(HDR_FIRST);
                rx_bytes.push_back(8'($urandom()));
            end else begin
                rx_bytes.push_back(HDR_FIRST);
                queue_frame(8'($urandom_range(5, 12)), {$urandom(), 8'($urandom())}, 1'b0);
            end
        end
        n_items = rx_bytes.size();

        // Synchronous reset, released between rising edges.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last byte to be taken and the last result to arrive,
        // then run on for DRAIN_CYCLES so that any stray result can still show.
        while (rx_bytes.size() != 0 || i_in_valid) @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Byte driver. A byte on offer stays unchanged until it is taken; only
    // then may the sender pause. Inputs move on the falling edge.
    always @(negedge i_clk) begin
        int idle_pct;
        case (idle_regime())
            0:       idle_pct = 24;
            1:       idle_pct = 74;
            default: idle_pct = 0;
        endcase
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !rx_taken) begin
            i_in_valid <= 1'b1;
        end else if (rx_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
            i_in_valid <= 1'b1;
            i_rx_byte  <= rx_bytes.pop_front();
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Result receiver stall. In the last regime, where nobody idles, the
    // receiver once holds off for a long stretch while bytes keep coming, so
    // that a waiting result backs up into the input register and the block
    // has to stall its input.
    always @(negedge i_clk) begin
        int stall_pct;
        case (idle_regime())
            0:       stall_pct = 74;
            1:       stall_pct = 24;
            default: stall_pct = 0;
        endcase
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && n_accepted >= (n_items * 5) / 6) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor. Both channels are sampled at the rising edge. The input side
    // is handled first, so a prediction is always queued before a result
    // for that byte can be compared.
    always @(posedge i_clk) begin
        t_frame_result exp_r;
        bit            res_taken;
        if (i_rst_n) begin
            rx_taken  = i_in_valid && !o_in_stall;
            res_taken = o_out_valid && !i_out_stall;
            if (rx_taken) begin
                deframe_byte(i_rx_byte);
                n_accepted++;
            end
            if (res_taken) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with none expected, status %0d", $time, o_status);
                    n_errors++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (o_status !== exp_r.status) begin
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, exp_r.status, o_status);
                        n_errors++;
                    end
                    if (o_speed_one !== exp_r.speed_one) begin
                        $display("%0t: speed_one expected %0d, actual %0d",
                                 $time, exp_r.speed_one, o_speed_one);
                        n_errors++;
                    end
                    if (o_speed_two !== exp_r.speed_two) begin
                        $display("%0t: speed_two expected %0d, actual %0d",
                                 $time, exp_r.speed_two, o_speed_two);
                        n_errors++;
                    end
                    if (o_control_flags !== exp_r.flags) begin
                        $display("%0t: control_flags expected 0x%02h, actual 0x%02h",
                                 $time, exp_r.flags, o_control_flags);
                        n_errors++;
                    end
                end
            end
            // Watchdog: too long without any handshake means a hang.
            quiet_count = (rx_taken || res_taken) ? 0 : quiet_count + 1;
            if (quiet_count >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("tb_top failed");
                $finish;
            end
        end else begin
            rx_taken = 1'b0;
        end
    end

endmodule
